### src/xpca_pkg.sv
// Package with shared constants, types and the popcount function of the XNOR popcount accumulator.
`timescale 1ns / 1ps

package xpca_pkg;

  localparam int unsigned LANES      = 16;
  localparam int unsigned LANE_W     = $clog2(LANES);
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned PC_W       = $clog2(WORD_BITS + 1);
  localparam int unsigned OPS_W      = 20;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PROD_W     = 2 * SCALE_W;
  localparam int unsigned DIFF_W     = COUNT_BITS + 2;
  localparam int unsigned MUL_W      = DIFF_W + PROD_W + 1;
  localparam int unsigned RES_W      = 54;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MULT
  } ctrl_state_e;

  typedef struct packed {
    logic acc_en;
    logic fin_en;
    logic scale_en;
    logic load_en;
  } dp_cmd_t;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### src/xpca_if.sv
// Handshake interfaces for the input item channel and the result channel.
`timescale 1ns / 1ps

interface xpca_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [xpca_pkg::WORD_BITS-1:0]        source_word;
  logic [xpca_pkg::WORD_BITS-1:0]        weight_word;
  logic [xpca_pkg::LANE_W-1:0]           lane;
  logic                                  finish;
  logic [xpca_pkg::OPS_W-1:0]            op_count;
  logic [xpca_pkg::SCALE_W-1:0]          alpha_scale;
  logic [xpca_pkg::SCALE_W-1:0]          k_scale;

  modport source (
    output valid, source_word, weight_word, lane, finish, op_count, alpha_scale, k_scale,
    input  ready
  );
  modport sink (
    input  valid, source_word, weight_word, lane, finish, op_count, alpha_scale, k_scale,
    output ready
  );
endinterface

interface xpca_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [xpca_pkg::RES_W-1:0]     scaled_result;
  logic [xpca_pkg::LANE_W-1:0]           result_lane;
  logic                                  saturated;

  modport source (
    output valid, scaled_result, result_lane, saturated,
    input  ready
  );
  modport sink (
    input  valid, scaled_result, result_lane, saturated,
    output ready
  );
endinterface

### src/xnor_popcount_conv_accumulator.sv
// Top level of the binary convolution accumulator: controller plus datapath.
// An accumulate beat is taken in any idle cycle and updates its lane at that clock edge.
// A finish beat presents its result beat after two steps (scale multiply,
// then the signed product into the result register); input stalls in those two steps,
// and longer while an earlier result beat is still waiting to be taken.
// Sustained rate: one accumulate beat per cycle while idle; no beat during a finish.
// Reset clears all lane counts, saturation flags, the controller state and result valid.
`timescale 1ns / 1ps

module xnor_popcount_conv_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  xpca_in_if.sink     in_i,
  xpca_out_if.source  out_o
);

  xpca_pkg::dp_cmd_t cmd;

  xpca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_finish_i (in_i.finish),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  xpca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .source_word_i   (in_i.source_word),
    .weight_word_i   (in_i.weight_word),
    .lane_i          (in_i.lane),
    .op_count_i      (in_i.op_count),
    .alpha_scale_i   (in_i.alpha_scale),
    .k_scale_i       (in_i.k_scale),
    .scaled_result_o (out_o.scaled_result),
    .result_lane_o   (out_o.result_lane),
    .saturated_o     (out_o.saturated)
  );

endmodule

### src/xpca_ctrl.sv
// Controller state machine that sequences accumulate and finish beats.
`timescale 1ns / 1ps

module xpca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_finish_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output xpca_pkg::dp_cmd_t cmd_o
);

  xpca_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xpca_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      xpca_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i && !in_finish_i;
        cmd_o.fin_en = in_valid_i && in_finish_i;
        if (in_valid_i && in_finish_i) begin
          state_d = xpca_pkg::ST_SCALE;
        end
      end
      xpca_pkg::ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = xpca_pkg::ST_MULT;
      end
      xpca_pkg::ST_MULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_en = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = xpca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = xpca_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_fin_to_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_finish_i) |=> (state_q == xpca_pkg::ST_SCALE))
    else $error("finish beat did not start the scaling step");

  a_scale_to_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xpca_pkg::ST_SCALE) |=> (state_q == xpca_pkg::ST_MULT))
    else $error("scaling step was not followed by the multiply step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_en |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while holding an untaken beat");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped without being taken");
`endif

endmodule

### src/xpca_dp.sv
// Datapath with the lane accumulators, the scaling multipliers and the result register.
`timescale 1ns / 1ps

module xpca_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  xpca_pkg::dp_cmd_t                    cmd_i,
  input  logic [xpca_pkg::WORD_BITS-1:0]       source_word_i,
  input  logic [xpca_pkg::WORD_BITS-1:0]       weight_word_i,
  input  logic [xpca_pkg::LANE_W-1:0]          lane_i,
  input  logic [xpca_pkg::OPS_W-1:0]           op_count_i,
  input  logic [xpca_pkg::SCALE_W-1:0]         alpha_scale_i,
  input  logic [xpca_pkg::SCALE_W-1:0]         k_scale_i,
  output logic signed [xpca_pkg::RES_W-1:0]    scaled_result_o,
  output logic [xpca_pkg::LANE_W-1:0]          result_lane_o,
  output logic                                 saturated_o
);

  logic [xpca_pkg::COUNT_BITS-1:0] cnt_q [xpca_pkg::LANES];
  logic [xpca_pkg::LANES-1:0]      sat_q;

  logic [xpca_pkg::PC_W-1:0]       pc;
  logic [xpca_pkg::COUNT_BITS:0]   sum;
  logic                            sum_full;

  logic [xpca_pkg::COUNT_BITS-1:0] fin_cnt_q;
  logic                            fin_sat_q;
  logic [xpca_pkg::LANE_W-1:0]     fin_lane_q;
  logic [xpca_pkg::OPS_W-1:0]      ops_q;
  logic [xpca_pkg::SCALE_W-1:0]    alpha_q;
  logic [xpca_pkg::SCALE_W-1:0]    k_q;

  logic [xpca_pkg::PROD_W-1:0]     scale_q;
  logic signed [xpca_pkg::DIFF_W-1:0] diff_q;
  logic signed [xpca_pkg::MUL_W-1:0]  prod;

  logic signed [xpca_pkg::RES_W-1:0] res_q;
  logic [xpca_pkg::LANE_W-1:0]       res_lane_q;
  logic                              res_sat_q;

  assign pc       = xpca_pkg::popcount(~(source_word_i ^ weight_word_i));
  assign sum      = {1'b0, cnt_q[lane_i]}
                  + {{(xpca_pkg::COUNT_BITS + 1 - xpca_pkg::PC_W){1'b0}}, pc};
  assign sum_full = (sum >= {1'b0, xpca_pkg::COUNT_MAX});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xpca_pkg::LANES; i++) begin
        cnt_q[i] <= '0;
      end
      sat_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (sum_full) begin
        cnt_q[lane_i] <= xpca_pkg::COUNT_MAX;
        sat_q[lane_i] <= 1'b1;
      end else begin
        cnt_q[lane_i] <= sum[xpca_pkg::COUNT_BITS-1:0];
      end
    end else if (cmd_i.fin_en) begin
      cnt_q[lane_i] <= '0;
      sat_q[lane_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      fin_cnt_q  <= cnt_q[lane_i];
      fin_sat_q  <= sat_q[lane_i];
      fin_lane_q <= lane_i;
      ops_q      <= op_count_i;
      alpha_q    <= alpha_scale_i;
      k_q        <= k_scale_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      scale_q <= xpca_pkg::PROD_W'(alpha_q) * xpca_pkg::PROD_W'(k_q);
      diff_q  <= $signed({1'b0, fin_cnt_q, 1'b0}) - $signed({2'b00, ops_q});
    end
  end

  // The magnitude bound of the difference keeps the product inside the result range.
  assign prod = diff_q * $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      res_q      <= prod[xpca_pkg::RES_W-1:0];
      res_lane_q <= fin_lane_q;
      res_sat_q  <= fin_sat_q;
    end
  end

  assign scaled_result_o = res_q;
  assign result_lane_o   = res_lane_q;
  assign saturated_o     = res_sat_q;

endmodule
